// File: rtl/hafo_pkg.sv
// Shared package for the heading-angle pipeline: field widths, fixed-point
// coefficients and the sideband record that travels alongside each beat.
// No dependencies.
`default_nettype none

package hafo_pkg;

  localparam int OFS_W  = 16;  // input offset width
  localparam int MAG_W  = 16;  // magnitude width, 32768 fits unsigned
  localparam int R16_W  = 17;  // Q1.16 ratio, 0..65536
  localparam int Q30_W  = 31;  // Q2.30 powers, 0..2^30
  localparam int TERM_W = 30;  // coefficient times power, below 2^30
  localparam int ACC_W  = 33;  // signed series accumulator
  localparam int COEF_W = 29;
  localparam int DEGK_W = 22;
  localparam int DEG_W  = Q30_W + DEGK_W;  // Q.46 degrees
  localparam int BASE_W = 7;               // base angle 0..90
  localparam int HDG_W  = 9;

  localparam int DIV_STAGES = R16_W;  // one quotient bit per stage

  localparam logic [COEF_W-1:0] C3_Q30 = 29'd357556027;
  localparam logic [COEF_W-1:0] C5_Q30 = 29'd214748365;
  localparam logic [COEF_W-1:0] C7_Q30 = 29'd153545081;
  localparam logic [COEF_W-1:0] C9_Q30 = 29'd59592671;
  localparam logic [DEGK_W-1:0] DEG_Q16 = 22'd3754938;
  localparam logic [DEG_W-1:0]  NINETY_Q46 = 53'd90 << 46;

  localparam logic signed [HDG_W-1:0] DEG_0    = 9'sd0;
  localparam logic signed [HDG_W-1:0] DEG_90   = 9'sd90;
  localparam logic signed [HDG_W-1:0] DEG_M90  = -9'sd90;
  localparam logic signed [HDG_W-1:0] DEG_180  = 9'sd180;

  typedef struct packed {
    logic                    fixed;      // axis case, result already known
    logic signed [HDG_W-1:0] fixed_deg;
    logic                    inv;        // ratio taken as |y|/|x|
    logic                    x_neg;
    logic                    y_neg;
  } hafo_side_t;

endpackage

`default_nettype wire

// File: rtl/hafo_div.sv
// Front end: magnitudes, axis cases and a restoring divider that forms the
// Q1.16 ratio one quotient bit per pipeline stage. Uses hafo_pkg.
`default_nettype none

module hafo_div import hafo_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [OFS_W-1:0] offset_x,
  input  wire logic signed [OFS_W-1:0] offset_y,
  output logic                         r_valid,
  input  wire logic                    r_stall,
  output logic [R16_W-1:0]             r16,
  output hafo_side_t                   r_side
);

  logic en;

  // Preparation stage.
  logic             p_valid;
  logic [MAG_W-1:0] p_lo;
  logic [MAG_W-1:0] p_hi;
  hafo_side_t       p_side;

  // Divider stages.
  logic             dv_valid [DIV_STAGES];
  logic [R16_W-1:0] dv_rem   [DIV_STAGES];
  logic [R16_W-1:0] dv_q     [DIV_STAGES];
  logic [MAG_W-1:0] dv_hi    [DIV_STAGES];
  hafo_side_t       dv_side  [DIV_STAGES];

  logic [R16_W-1:0] rem_next [DIV_STAGES];
  logic [R16_W-1:0] q_next   [DIV_STAGES];

  logic [MAG_W-1:0] ax, ay, lo_next, hi_next;
  hafo_side_t       side_next;

  assign en       = !(dv_valid[DIV_STAGES-1] && r_stall);
  assign in_stall = !en;

  always_comb begin
    ax = offset_x[OFS_W-1] ? MAG_W'(~offset_x + 1'b1) : MAG_W'(offset_x);
    ay = offset_y[OFS_W-1] ? MAG_W'(~offset_y + 1'b1) : MAG_W'(offset_y);
    side_next.inv   = ax > ay;
    side_next.x_neg = offset_x[OFS_W-1];
    side_next.y_neg = offset_y[OFS_W-1];
    lo_next = side_next.inv ? ay : ax;
    hi_next = side_next.inv ? ax : ay;
    side_next.fixed     = 1'b1;
    side_next.fixed_deg = DEG_0;
    if (offset_y == '0) begin
      if (offset_x == '0) begin
        side_next.fixed_deg = DEG_0;
      end else if (offset_x[OFS_W-1]) begin
        side_next.fixed_deg = DEG_M90;
      end else begin
        side_next.fixed_deg = DEG_90;
      end
    end else if (offset_x == '0) begin
      side_next.fixed_deg = offset_y[OFS_W-1] ? DEG_180 : DEG_0;
    end else begin
      side_next.fixed = 1'b0;
    end
  end

  // Since the numerator never exceeds the denominator, the partial remainder
  // entering the first step is simply the numerator itself.
  always_comb begin
    logic [R16_W-1:0] rin;
    rin = {1'b0, p_lo};
    if (rin >= {1'b0, p_hi}) begin
      rem_next[0] = rin - {1'b0, p_hi};
      q_next[0]   = R16_W'(1);
    end else begin
      rem_next[0] = rin;
      q_next[0]   = '0;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      rin = {dv_rem[s-1][R16_W-2:0], 1'b0};
      if (rin >= {1'b0, dv_hi[s-1]}) begin
        rem_next[s] = rin - {1'b0, dv_hi[s-1]};
        q_next[s]   = {dv_q[s-1][R16_W-2:0], 1'b1};
      end else begin
        rem_next[s] = rin;
        q_next[s]   = {dv_q[s-1][R16_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) dv_valid[s] <= 1'b0;
    end else if (en) begin
      p_valid     <= in_valid;
      dv_valid[0] <= p_valid;
      for (int s = 1; s < DIV_STAGES; s++) dv_valid[s] <= dv_valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo       <= lo_next;
      p_hi       <= hi_next;
      p_side     <= side_next;
      dv_hi[0]   <= p_hi;
      dv_side[0] <= p_side;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_hi[s]   <= dv_hi[s-1];
        dv_side[s] <= dv_side[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_rem[s] <= rem_next[s];
        dv_q[s]   <= q_next[s];
      end
    end
  end

  assign r_valid = dv_valid[DIV_STAGES-1];
  assign r16     = dv_q[DIV_STAGES-1];
  assign r_side  = dv_side[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/hafo_poly.sv
// Arctangent series in Q2.30: odd powers, coefficient terms and a running
// sum, one multiplier per path per stage. Uses hafo_pkg.
`default_nettype none

module hafo_poly import hafo_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             r_valid,
  output logic                  r_stall,
  input  wire logic [R16_W-1:0] r16,
  input  wire hafo_side_t       r_side,
  output logic                  s_valid,
  input  wire logic             s_stall,
  output logic [Q30_W-1:0]      series,
  output hafo_side_t            s_side
);

  localparam int NST = 7;

  logic       v   [NST];
  hafo_side_t sd  [NST];
  logic       en;

  logic [R16_W-1:0]  r16_1, r16_2, r16_3;
  logic [Q30_W-1:0]  r2_1, r2_2, r2_3, r2_4;
  logic [Q30_W-1:0]  r3_2, r5_3, r7_4, r9_5;
  logic [TERM_W-1:0] t3_3, t5_4, t7_5, t9_6;
  logic signed [ACC_W-1:0] acc_4, acc_5, acc_6;
  logic [Q30_W-1:0]  sum_7;

  logic [2*R16_W-1:0]        p_r2;
  logic [Q30_W+R16_W-1:0]    p_r3;
  logic [2*Q30_W-1:0]        p_r5, p_r7, p_r9;
  logic [COEF_W+Q30_W-1:0]   p_t3, p_t5, p_t7, p_t9;
  logic signed [ACC_W-1:0]   acc_7;

  assign en      = !(v[NST-1] && s_stall);
  assign r_stall = !en;

  // Multiplying by the ratio in Q2.30 is the Q1.16 value shifted by 14, so the
  // first two products use the narrow ratio and fold the shift into the slice.
  always_comb begin
    p_r2  = r16 * r16;
    p_r3  = r2_1 * r16_1;
    p_r5  = r3_2 * r2_2;
    p_t3  = C3_Q30 * r3_2;
    p_r7  = r5_3 * r2_3;
    p_t5  = C5_Q30 * r5_3;
    p_r9  = r7_4 * r2_4;
    p_t7  = C7_Q30 * r7_4;
    p_t9  = C9_Q30 * r9_5;
    acc_7 = acc_6 + $signed({3'b000, t9_6});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= r_valid;
      for (int i = 1; i < NST; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= r_side;
      for (int i = 1; i < NST; i++) sd[i] <= sd[i-1];
      r16_1 <= r16;
      r2_1  <= p_r2[Q30_W+1:2];
      r16_2 <= r16_1;
      r2_2  <= r2_1;
      r3_2  <= p_r3[Q30_W+15:16];
      r16_3 <= r16_2;
      r2_3  <= r2_2;
      r5_3  <= p_r5[Q30_W+29:30];
      t3_3  <= p_t3[TERM_W+29:30];
      r2_4  <= r2_3;
      r7_4  <= p_r7[Q30_W+29:30];
      t5_4  <= p_t5[TERM_W+29:30];
      acc_4 <= $signed({2'b00, r16_3, 14'b0}) - $signed({3'b000, t3_3});
      r9_5  <= p_r9[Q30_W+29:30];
      t7_5  <= p_t7[TERM_W+29:30];
      acc_5 <= acc_4 + $signed({3'b000, t5_4});
      t9_6  <= p_t9[TERM_W+29:30];
      acc_6 <= acc_5 - $signed({3'b000, t7_5});
      sum_7 <= acc_7[ACC_W-1] ? '0 : acc_7[Q30_W-1:0];
    end
  end

  assign s_valid = v[NST-1];
  assign s_side  = sd[NST-1];
  assign series  = sum_7;

endmodule

`default_nettype wire

// File: rtl/hafo_angle.sv
// Back end: scaling to degrees, the ninety-degree fold for inverted ratios,
// quadrant mapping and the output register. Uses hafo_pkg.
`default_nettype none

module hafo_angle import hafo_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_valid,
  output logic                         s_stall,
  input  wire logic [Q30_W-1:0]        series,
  input  wire hafo_side_t              s_side,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [HDG_W-1:0]      heading_deg
);

  logic en;
  logic v1, v2, v3;
  hafo_side_t sd1, sd2;
  logic [DEG_W-1:0]  deg_1;
  logic [BASE_W-1:0] base_2;
  logic signed [HDG_W-1:0] hdg_3;

  logic [DEG_W-1:0]  deg_c, diff;
  logic [BASE_W-1:0] base_next;
  logic signed [HDG_W-1:0] a9, hdg_next;

  assign en      = !(v3 && out_stall);
  assign s_stall = !en;

  always_comb begin
    deg_c = (deg_1 > NINETY_Q46) ? NINETY_Q46 : deg_1;
    diff  = NINETY_Q46 - deg_c;
    base_next = sd1.inv ? diff[DEG_W-1:46] : deg_1[DEG_W-1:46];
  end

  always_comb begin
    a9 = $signed({2'b00, base_2});
    if (sd2.fixed) begin
      hdg_next = sd2.fixed_deg;
    end else if (!sd2.x_neg && sd2.y_neg) begin
      hdg_next = DEG_180 - a9;
    end else if (sd2.x_neg && sd2.y_neg) begin
      hdg_next = a9 - DEG_180;
    end else if (sd2.x_neg) begin
      hdg_next = -a9;
    end else begin
      hdg_next = a9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_1  <= series * DEG_Q16;
      sd1    <= s_side;
      base_2 <= base_next;
      sd2    <= sd1;
      hdg_3  <= hdg_next;
    end
  end

  assign out_valid   = v3;
  assign heading_deg = hdg_3;

endmodule

`default_nettype wire

// File: rtl/heading_angle_from_offsets_top.sv
// Top level of the heading-angle pipeline: front end with divider, series
// unit and angle back end. Uses hafo_pkg, hafo_div, hafo_poly, hafo_angle.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   offset_x, offset_y (s16 each)
//   out      output     out_valid / out_stall heading_deg (s9)
//
// One beat is accepted every cycle while the output is not held up; each
// beat gives exactly one result after passing one preparation stage,
// seventeen divider stages of one quotient bit each, seven series stages and
// three angle stages. The divider chain is the longest section.
// Reset is synchronous and clears only the valid bits; payload registers are
// left as they are. A stall from the output freezes only sections whose last
// stage holds a beat, so earlier sections keep filling their empty stages.
`default_nettype none

module heading_angle_from_offsets_top import hafo_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [OFS_W-1:0] offset_x,
  input  wire logic signed [OFS_W-1:0] offset_y,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [HDG_W-1:0]      heading_deg
);

  // Ratio from the divider to the series unit.
  logic             r_valid, r_stall;
  logic [R16_W-1:0] r16;
  hafo_side_t       r_side;

  // Clamped series sum from the series unit to the back end.
  logic             s_valid, s_stall;
  logic [Q30_W-1:0] series;
  hafo_side_t       s_side;

  hafo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .r_valid  (r_valid),
    .r_stall  (r_stall),
    .r16      (r16),
    .r_side   (r_side)
  );

  hafo_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .r_valid (r_valid),
    .r_stall (r_stall),
    .r16     (r16),
    .r_side  (r_side),
    .s_valid (s_valid),
    .s_stall (s_stall),
    .series  (series),
    .s_side  (s_side)
  );

  hafo_angle u_angle (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_valid),
    .s_stall     (s_stall),
    .series      (series),
    .s_side      (s_side),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .heading_deg (heading_deg)
  );

  // The input can only be held up when the stall has come all the way back
  // from the output through every full section.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled without an output stall");

  // Every result lies within a half turn either way.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_deg >= -9'sd180 && heading_deg <= 9'sd180))
    else $error("heading out of range");

  // No result beat survives a reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  // A stall inside the pipeline never stalls an empty series section.
  a_inner_stall: assert property (@(posedge clk) disable iff (rst)
    r_stall |-> (s_valid && s_stall))
    else $error("series section stalled while its last stage is empty");

endmodule

`default_nettype wire
